[rtl/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit allocator
// Field widths, operation and status codes, the command words that go to
// the cells, and elaboration helpers for the selection tree.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  localparam int ADDR_W   = 24;
  localparam int LEN_W    = 24;
  localparam int RANGE_W  = 25;
  localparam int SLOT_W   = 6;
  localparam int TOTAL_W  = 7;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_BANK_SIZE   = 16384;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_CLAIM  = 2'd1,
    OP_GIVE   = 2'd2,
    OP_APPEND = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_BAD_SLOT  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // One table entry.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  size;
  } ent_t;

  // Search command broadcast to every cell.
  typedef struct packed {
    opcode_t            op;
    logic [LEN_W-1:0]   len;
    logic [RANGE_W-1:0] low;
    logic [RANGE_W-1:0] high;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W:0]    addr_end;
    logic               addr_unaligned;
  } search_t;

  // Update command: write one entry, or remove one and close the gap.
  typedef struct packed {
    logic en;
    logic rm;
    ent_t ent;
  } upd_t;

  // Number of radix-8 tree levels needed to cover n leaves (at least one).
  function automatic int clog8(input int n);
    int l;
    l = 1;
    while ((1 << (3 * l)) < n) l++;
    return l;
  endfunction

  // Offset of tree level g in a flat node list, leaves being level 0.
  function automatic int lvl_off(input int levels, input int g);
    int s;
    s = 0;
    for (int k = 0; k < g; k++) s += 1 << (3 * (levels - k));
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/free_space_first_fit_allocator.sv]
// ----------------------------------------------------------------------------
// free_space_first_fit_allocator: ordered free-extent table with first fit
// Keeps up to TABLE_DEPTH free extents and serves find, claim, give and
// append requests against them.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one request word: s_tuser carries the opcode and
//   s_tdata the span, range and slot fields. The m_ channel returns one
//   result word per request: s_tuser-like m_tuser carries the status and
//   m_tdata the found slot, address, length and the new entry count.
//   Requests are handled one at a time. Every cell tests its entry in
//   parallel and registers its flag, then a registered radix-8 tree picks
//   the first match. The result is then evaluated and registered, and the
//   cells are written as the result word leaves; only after that write is
//   the next request accepted. Removal closes the gap by shifting every
//   higher cell down by one, all in the same write.
//   Reset empties the table; entry contents are not cleared and are never
//   read before they are written. If the receiver stalls, the word waits in
//   the output register; one more request is still taken, and its result
//   and table write are held back until the output register is free.
//   BANK_SIZE must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module free_space_first_fit_allocator import ffa_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int BANK_SIZE   = DEF_BANK_SIZE
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // span_address, span_length, range_low, range_high, slot_index
  input  wire logic [103:0] s_tdata,
  // opcode
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // found_slot, found_address, found_length, entry_total, zero fill
  output logic [63:0]       m_tdata,
  // status
  output logic [2:0]        m_tuser
);

  localparam int IW        = $clog2(TABLE_DEPTH);
  localparam int CW        = $clog2(TABLE_DEPTH + 1);
  localparam int BANK_BITS = $clog2(BANK_SIZE);
  localparam int LEVELS    = clog8(TABLE_DEPTH);
  localparam int TW        = $clog2(LEVELS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLAG,
    S_TREE,
    S_EVAL,
    S_WRITE
  } state_t;

  state_t              state;
  logic [TW-1:0]       tcnt;
  logic [CW-1:0]       count;
  search_t             cmd;
  logic [SLOT_W-1:0]   slot;

  // Result and pending update.
  status_t             res_status;
  logic [IW-1:0]       res_slot;
  logic [ADDR_W-1:0]   res_addr;
  logic [LEN_W-1:0]    res_len;
  logic [CW-1:0]       res_total;
  upd_t                upd;
  logic [IW-1:0]       upd_idx;

  // Evaluation of the tree result.
  status_t             ev_status;
  logic [IW-1:0]       ev_slot;
  logic [ADDR_W-1:0]   ev_addr;
  logic [LEN_W-1:0]    ev_len;
  logic [CW-1:0]       ev_total;
  upd_t                ev_upd;
  logic [IW-1:0]       ev_idx;

  logic                t_found;
  logic                t_kind;
  logic [IW-1:0]       t_idx;
  ent_t                t_ent;

  logic                cell_hit  [TABLE_DEPTH];
  logic                cell_kind [TABLE_DEPTH];
  ent_t                cell_ent  [TABLE_DEPTH];
  upd_t                cell_upd;

  logic                out_free;
  logic                accept;
  logic [LEN_W:0]      grow_sum;
  logic [LEN_W-1:0]    grow_sat;
  logic [LEN_W-1:0]    shrink;
  logic                full;
  logic [LEN_W:0]      in_end;

  assign s_tready = state == S_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign in_end   = {1'b0, s_tdata[23:0]} + {1'b0, s_tdata[47:24]};

  always_comb begin
    cell_upd    = upd;
    cell_upd.en = upd.en && (state == S_WRITE) && out_free;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ent_t nb;
    if (i == TABLE_DEPTH - 1) begin : g_top
      assign nb = cell_ent[i];
    end else begin : g_mid
      assign nb = cell_ent[i+1];
    end
    ffa_cell #(
      .INDEX     (i),
      .DEPTH     (TABLE_DEPTH),
      .BANK_BITS (BANK_BITS)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .slot    (slot),
      .count   (count),
      .upd     (cell_upd),
      .upd_idx (upd_idx),
      .nb      (nb),
      .ent     (cell_ent[i]),
      .hit     (cell_hit[i]),
      .kind    (cell_kind[i])
    );
  end

  ffa_pick #(
    .DEPTH (TABLE_DEPTH)
  ) u_pick (
    .clk        (clk),
    .hit        (cell_hit),
    .kind       (cell_kind),
    .ent        (cell_ent),
    .found      (t_found),
    .found_kind (t_kind),
    .found_idx  (t_idx),
    .found_ent  (t_ent)
  );

  assign grow_sum = {1'b0, t_ent.size} + {1'b0, cmd.len};
  assign grow_sat = grow_sum[LEN_W] ? '1 : grow_sum[LEN_W-1:0];
  assign shrink   = t_ent.size - cmd.len;
  assign full     = count == CW'(TABLE_DEPTH);

  always_comb begin
    ev_status = ST_OK;
    ev_slot   = '0;
    ev_addr   = '0;
    ev_len    = '0;
    ev_total  = count;
    ev_upd    = '0;
    ev_idx    = t_idx;
    case (cmd.op)
      OP_FIND: begin
        if (t_found && t_kind) begin
          ev_slot = t_idx;
          ev_addr = t_ent.start;
          ev_len  = t_ent.size;
        end else begin
          ev_status = ST_NOT_FOUND;
        end
      end
      OP_CLAIM: begin
        if (!t_found) begin
          ev_status = ST_BAD_SLOT;
        end else begin
          ev_slot = t_idx;
          ev_addr = t_ent.start;
          ev_len  = t_ent.size;
          if (cmd.len > t_ent.size) begin
            ev_status = ST_TOO_LONG;
          end else begin
            ev_upd.en        = 1'b1;
            ev_upd.ent.start = t_ent.start + cmd.len;
            ev_upd.ent.size  = shrink;
            // An emptied entry leaves the table and the rest moves down.
            if (shrink == '0) begin
              ev_upd.rm = 1'b1;
              ev_total  = count - 1'b1;
            end
          end
        end
      end
      default: begin
        if ((cmd.op == OP_GIVE) && t_found) begin
          ev_upd.en        = 1'b1;
          ev_upd.ent.start = t_kind ? cmd.addr : t_ent.start;
          ev_upd.ent.size  = grow_sat;
        end else if (full) begin
          ev_status = ST_FULL;
        end else begin
          ev_upd.en        = 1'b1;
          ev_upd.ent.start = cmd.addr;
          ev_upd.ent.size  = cmd.len;
          ev_idx           = count[IW-1:0];
          ev_total         = count + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
      tcnt     <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != S_WRITE)) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd.op             <= opcode_t'(s_tuser[1:0]);
            cmd.addr           <= s_tdata[23:0];
            cmd.len            <= s_tdata[47:24];
            cmd.low            <= s_tdata[72:48];
            cmd.high           <= s_tdata[97:73];
            cmd.addr_end       <= in_end;
            cmd.addr_unaligned <= s_tdata[BANK_BITS-1:0] != '0;
            slot               <= s_tdata[103:98];
            state              <= S_FLAG;
          end
        end
        S_FLAG: begin
          tcnt  <= '0;
          state <= S_TREE;
        end
        S_TREE: begin
          if (tcnt == TW'(LEVELS - 1)) begin
            state <= S_EVAL;
          end else begin
            tcnt <= tcnt + 1'b1;
          end
        end
        S_EVAL: begin
          res_status <= ev_status;
          res_slot   <= ev_slot;
          res_addr   <= ev_addr;
          res_len    <= ev_len;
          res_total  <= ev_total;
          upd        <= ev_upd;
          upd_idx    <= ev_idx;
          state      <= S_WRITE;
        end
        S_WRITE: begin
          // The table write and the result word leave together.
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {3'b000, TOTAL_W'(res_total), res_len, res_addr,
                         SLOT_W'(res_slot)};
            count    <= res_total;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/ffa_cell.sv]
// ----------------------------------------------------------------------------
// ffa_cell: one table entry of the allocator
// Holds one extent, tests it against the broadcast search command, and
// either takes a new value or the value of its upper neighbor on update.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_cell import ffa_pkg::*; #(
  parameter int INDEX     = 0,
  parameter int DEPTH     = DEF_TABLE_DEPTH,
  parameter int BANK_BITS = 14
) (
  input  wire logic                       clk,
  input  wire search_t                    cmd,
  input  wire logic [SLOT_W-1:0]          slot,
  input  wire logic [$clog2(DEPTH+1)-1:0] count,
  input  wire upd_t                       upd,
  input  wire logic [$clog2(DEPTH)-1:0]   upd_idx,
  input  wire ent_t                       nb,
  output ent_t                            ent,
  output logic                            hit,
  output logic                            kind
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic              live;
  logic              stop;
  logic              fits;
  logic              aligned;
  logic              joins_front;
  logic              after;
  logic [ADDR_W:0]   ent_end;
  logic              hit_next;
  logic              kind_next;

  assign live        = CW'(INDEX) < count;
  assign stop        = {1'b0, ent.start} >= cmd.high;
  assign fits        = ({1'b0, ent.start} >= cmd.low) && (ent.size >= cmd.len);
  assign aligned     = ent.start[BANK_BITS-1:0] == '0;
  assign ent_end     = {1'b0, ent.start} + {1'b0, ent.size};
  assign joins_front = {1'b0, ent.start} == cmd.addr_end;
  assign after       = cmd.addr_unaligned && (ent_end == {1'b0, cmd.addr});

  always_comb begin
    hit_next  = 1'b0;
    kind_next = 1'b0;
    case (cmd.op)
      OP_FIND: begin
        // A start at or above the bound ends the scan without a match.
        hit_next  = live && (stop || fits);
        kind_next = !stop;
      end
      OP_CLAIM: begin
        hit_next = live && (32'(slot) == INDEX);
      end
      OP_GIVE: begin
        hit_next  = live && !aligned && (joins_front || after);
        kind_next = joins_front;
      end
      default: begin
        hit_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    hit  <= hit_next;
    kind <= kind_next;
    if (upd.en) begin
      if (upd.rm) begin
        if (IW'(INDEX) >= upd_idx) ent <= nb;
      end else if (IW'(INDEX) == upd_idx) begin
        ent <= upd.ent;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ffa_pick.sv]
// ----------------------------------------------------------------------------
// ffa_pick: first-match selection tree
// A registered radix-8 tree that returns the lowest-numbered cell whose
// flag is set, together with its index, kind bit and entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_pick import ffa_pkg::*; #(
  parameter int DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     hit  [DEPTH],
  input  wire logic                     kind [DEPTH],
  input  wire ent_t                     ent  [DEPTH],
  output logic                          found,
  output logic                          found_kind,
  output logic [$clog2(DEPTH)-1:0]      found_idx,
  output ent_t                          found_ent
);

  localparam int IW     = $clog2(DEPTH);
  localparam int LEVELS = clog8(DEPTH);
  localparam int LEAVES = 1 << (3 * LEVELS);
  localparam int INNER  = lvl_off(LEVELS, LEVELS + 1) - LEAVES;

  typedef struct packed {
    logic          hit;
    logic          kind;
    logic [IW-1:0] idx;
    ent_t          ent;
  } node_t;

  node_t leaf  [LEAVES];
  node_t inner [INNER];
  node_t pick  [INNER];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < DEPTH) begin : g_used
      assign leaf[i] = '{hit: hit[i], kind: kind[i], idx: IW'(i), ent: ent[i]};
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  for (genvar g = 1; g <= LEVELS; g++) begin : g_level
    for (genvar p = 0; p < (LEAVES >> (3 * g)); p++) begin : g_node
      localparam int DST = lvl_off(LEVELS, g) + p - LEAVES;
      localparam int SRC = lvl_off(LEVELS, g - 1) + 8 * p;
      if (g == 1) begin : g_from_leaf
        always_comb begin
          pick[DST] = leaf[SRC+7];
          for (int j = 6; j >= 0; j--) begin
            if (leaf[SRC+j].hit) pick[DST] = leaf[SRC+j];
          end
        end
      end else begin : g_from_inner
        always_comb begin
          pick[DST] = inner[SRC-LEAVES+7];
          for (int j = 6; j >= 0; j--) begin
            if (inner[SRC-LEAVES+j].hit) pick[DST] = inner[SRC-LEAVES+j];
          end
        end
      end
      always_ff @(posedge clk) begin
        inner[DST] <= pick[DST];
      end
    end
  end

  assign found      = inner[INNER-1].hit;
  assign found_kind = inner[INNER-1].kind;
  assign found_idx  = inner[INNER-1].idx;
  assign found_ent  = inner[INNER-1].ent;

endmodule

`default_nettype wire
